// ----- design/tcw_pkg.sv -----
// shared types and constants for the text console writer
package tcw_pkg;

    localparam logic [1:0]  REQ_PUT    = 2'd0;
    localparam logic [1:0]  REQ_READ   = 2'd1;
    localparam logic [1:0]  REQ_CLEAR  = 2'd2;

    localparam logic [7:0]  CH_NEWLINE = 8'd10;
    localparam logic [7:0]  CH_RETURN  = 8'd13;

    localparam int          CELL_W     = 16;
    // attribute in the high byte, character in the low byte
    localparam logic [15:0] BLANK_CELL = 16'h0720;

    localparam int          ROW_OUT_W  = 5;
    localparam int          COL_OUT_W  = 7;
    localparam int          POS_OUT_W  = 11;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]           read_char;
        logic [7:0]           read_attr;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [POS_OUT_W-1:0] cursor_pos;
        logic                 scrolled;
    } t_out_item;

    typedef struct packed {
        logic       put;
        logic       home;
        logic [7:0] code;
    } t_cur_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP
    } t_state;

endpackage

// ----- design/tcw_ram.sv -----
// generic single write port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/tcw_cursor.sv -----
// cursor row, column and linear position with wrap and scroll detection
module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25,
    localparam int AW = $clog2(ROWS * COLS),
    localparam int RW = $clog2(ROWS),
    localparam int CW = $clog2(COLS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cur_cmd      i_cmd,
    output logic [RW-1:0] o_row,
    output logic [CW-1:0] o_col,
    output logic [AW-1:0] o_pos,
    output logic [AW-1:0] o_addr,
    output logic          o_scroll
);

    localparam int LAST = (ROWS - 1) * COLS;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_pos, n_pos;
    logic          last_col;
    logic          last_row;
    logic          is_nl;
    logic          is_cr;

    assign last_col = (r_col == CW'(COLS - 1));
    assign last_row = (r_row == RW'(ROWS - 1));
    assign is_nl    = (i_cmd.code == CH_NEWLINE);
    assign is_cr    = (i_cmd.code == CH_RETURN);

    // a printable character in the last cell or a newline on the bottom row
    assign o_scroll = i_cmd.put && last_row && (is_nl || (!is_cr && last_col));

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_pos = r_pos;
        if (i_cmd.home) begin
            n_row = '0;
            n_col = '0;
            n_pos = '0;
        end else if (i_cmd.put) begin
            if (o_scroll) begin
                n_row = RW'(ROWS - 1);
                n_col = '0;
                n_pos = AW'(LAST);
            end else if (is_nl) begin
                n_row = r_row + 1'b1;
                n_col = '0;
                n_pos = r_pos - AW'(r_col) + AW'(COLS);
            end else if (is_cr) begin
                n_col = '0;
                n_pos = r_pos - AW'(r_col);
            end else if (last_col) begin
                n_row = r_row + 1'b1;
                n_col = '0;
                n_pos = r_pos + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_pos <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_pos <= n_pos;
        end
    end

    assign o_row  = n_row;
    assign o_col  = n_col;
    assign o_pos  = n_pos;
    assign o_addr = r_pos;

endmodule

// ----- design/text_console_writer.sv -----
// text console writer top level: request decode, store sweeps and result buffering
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------
//  request  | in        | i_in_valid / o_in_ready    | i_in
//  result   | out       | o_out_valid / i_out_ready  | o_out
//
// a put or clear gives its result as it is taken; a read gives its result from ST_READ, after the registered ram read
// a scroll rewrites the whole store through the single ram write port in a sweep
// a clear blanks the store in a sweep; the result leaves at acceptance
// after reset the store is blanked before a request is taken
// a result register and one skid entry let a request in while a result is waiting
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int NCELLS = ROWS * COLS;
    localparam int LAST   = (ROWS - 1) * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int CNTW   = $clog2(NCELLS + 1);

    t_state r_state, n_state;

    logic [CNTW-1:0]   r_cnt;
    logic              r_copy;
    logic              r_wv;
    logic [AW-1:0]     r_wa;
    logic              r_wsrc;
    logic              r_rd_ok;
    t_out_item         r_out;
    logic              r_out_valid;
    t_out_item         r_res;
    logic              r_res_valid;

    logic              in_fire;
    logic              out_fire;
    logic              is_put;
    logic              is_read;
    logic              is_clear;
    logic              is_print;
    logic              idx_ok;
    logic              sweep_go;

    t_cur_cmd          cur_cmd;
    logic [RW-1:0]     cur_row;
    logic [CW-1:0]     cur_col;
    logic [AW-1:0]     cur_pos;
    logic [AW-1:0]     cur_addr;
    logic              cur_scroll;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic              prod_valid;
    t_out_item         prod;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign is_put   = (i_in.req_type == REQ_PUT);
    assign is_read  = (i_in.req_type == REQ_READ);
    assign is_clear = (i_in.req_type == REQ_CLEAR);
    assign is_print = (i_in.char_code != CH_NEWLINE) && (i_in.char_code != CH_RETURN);
    assign idx_ok   = (32'(i_in.cell_index) < 32'(NCELLS));
    assign sweep_go = in_fire && (is_clear || (is_put && cur_scroll));

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tcw_cursor #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cur_cmd),
        .o_row    (cur_row),
        .o_col    (cur_col),
        .o_pos    (cur_pos),
        .o_addr   (cur_addr),
        .o_scroll (cur_scroll)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && is_read) begin
                    n_state = ST_READ;
                end else if (sweep_go) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                if (r_cnt == CNTW'(NCELLS)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_ready      = 1'b0;
        cur_cmd.put     = 1'b0;
        cur_cmd.home    = 1'b0;
        cur_cmd.code    = i_in.char_code;
        mem_we          = 1'b0;
        mem_waddr       = cur_addr;
        mem_wdata       = {i_in.color, i_in.char_code};
        mem_raddr       = AW'(i_in.cell_index);
        prod_valid      = 1'b0;
        prod.read_char  = '0;
        prod.read_attr  = '0;
        prod.cursor_row = ROW_OUT_W'(cur_row);
        prod.cursor_col = COL_OUT_W'(cur_col);
        prod.cursor_pos = POS_OUT_W'(cur_pos);
        prod.scrolled   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = !r_res_valid;
                cur_cmd.put   = in_fire && is_put;
                cur_cmd.home  = in_fire && is_clear;
                mem_we        = in_fire && is_put && is_print;
                prod_valid    = in_fire && !is_read;
                prod.scrolled = is_put && cur_scroll;
            end
            ST_READ: begin
                prod_valid = 1'b1;
                if (r_rd_ok) begin
                    prod.read_char = mem_rdata[7:0];
                    prod.read_attr = mem_rdata[15:8];
                end
            end
            ST_SWEEP: begin
                // read a row ahead; the write follows with the registered read data
                mem_we    = r_wv;
                mem_waddr = r_wa;
                mem_wdata = r_wsrc ? mem_rdata : BLANK_CELL;
                mem_raddr = (r_cnt < CNTW'(LAST)) ? AW'(r_cnt + CNTW'(COLS)) : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_cnt   <= '0;
            r_copy  <= 1'b0;
            r_wv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_wv   <= (r_cnt < CNTW'(NCELLS));
                r_cnt  <= r_cnt + 1'b1;
            end else begin
                r_wv <= 1'b0;
                if (sweep_go) begin
                    r_cnt  <= '0;
                    r_copy <= is_put;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa    <= r_cnt[AW-1:0];
        r_wsrc  <= r_copy && (r_cnt < CNTW'(LAST));
        if (in_fire) begin
            r_rd_ok <= idx_ok;
        end
    end

    // result register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (r_res_valid && (!r_out_valid || out_fire)) begin
            r_out       <= r_res;
            r_out_valid <= 1'b1;
            r_res_valid <= 1'b0;
        end else if (prod_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= prod;
                r_out_valid <= 1'b1;
            end else begin
                r_res       <= prod;
                r_res_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> r_out_valid)
        else $error("skid entry holds a transaction while the result register is empty");

    a_no_prod_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prod_valid |-> !r_res_valid)
        else $error("result produced while the skid entry is occupied");

    a_scroll_starts_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_put && cur_scroll) |=> (r_state == ST_SWEEP && r_copy))
        else $error("scroll did not start a copy sweep");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(NCELLS)))
        else $error("cell store write beyond the last cell");

endmodule
